>>> hw/rtl/kvev_pkg.sv
`default_nettype none
package kvev_pkg;

	// Default table depth
	localparam int SLOTS_DEF = 1024;

	// Fixed field widths
	localparam int BUDGET_W = 10;
	localparam int ROOM_W   = 7;
	localparam int KEPT_W   = 11;
	localparam int POS_W    = 32;
	localparam int VOTE_W   = 32;
	localparam int IDX_W    = 12;
	localparam int PROD_W   = 29;

	// Reset values of the registers
	localparam logic [BUDGET_W-1:0] BUDGET_RST = 10'd512;
	localparam logic [BUDGET_W-1:0] WINDOW_RST = 10'd32;

	// Fixed-point constants
	localparam logic [PROD_W-1:0] ONE_Q16  = 29'd65536;
	localparam logic [ROOM_W-1:0] ROOM_CAP = 7'd64;
	localparam logic [IDX_W-1:0]  IDX_MAX  = 12'd4095;

	// Opcodes
	typedef logic [1:0] op_t;
	localparam op_t OP_ATTN   = 2'd0;
	localparam op_t OP_APPEND = 2'd1;
	localparam op_t OP_EVICT  = 2'd2;
	localparam op_t OP_UNUSED = 2'd3;

	// Result status codes
	typedef logic [2:0] status_t;
	localparam status_t ST_APPENDED = 3'd0;
	localparam status_t ST_DROPPED  = 3'd1;
	localparam status_t ST_VICTIM   = 3'd2;
	localparam status_t ST_NONE     = 3'd3;
	localparam status_t ST_REFUSED  = 3'd4;

	// Register indexes
	localparam logic CFG_BUDGET = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	// Result offered by the evict engine
	typedef struct packed {
		logic              valid;
		status_t           status;
		logic [POS_W-1:0]  pos;
		logic              last;
		logic [KEPT_W-1:0] kept;
	} res_t;

endpackage
`default_nettype wire

>>> hw/rtl/kv_cache_vote_evictor.sv
`default_nettype none
// Vote-counting KV-cache evictor.
// Input channel (in_valid/in_stall) carries one item per transfer: attention
// elements (op 0), one per kept entry in table order, an append (op 1) that
// ends a decode step, or an evict (op 2). Output channel (out_valid/out_stall)
// carries results: one per append, and for an evict either one status result
// or one victim per removed entry, in ascending table order, last set on the
// final one. kept_count is the table size after the item.
// Attention elements give no result; their vote read-modify-write runs one
// stage behind, and an append or evict following one that votes is held
// while that vote write is pending. An append's result is registered and
// shows in the cycle after transfer. An evict runs one scan of the unprotected
// entries per victim through the single memory read port, then a compaction
// pass that reads, then processes, each entry. No input is taken during an
// evict. A held result in the output register blocks only items that give
// results; attention elements keep flowing. Reset empties the table to one
// entry (position 0, zero votes), budget 512, guard window 32; no clearing
// pass. Configuration writes (cfg_we) go straight into the registers.
module kv_cache_vote_evictor import kvev_pkg::*; #(
	parameter int MAX_SLOTS = SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_index,
	input  wire logic [BUDGET_W-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          op,
	input  wire logic [16:0]         attn_weight,
	input  wire logic [IDX_W-1:0]    step_len,
	input  wire logic [POS_W-1:0]    position,
	input  wire logic [ROOM_W-1:0]   victim_room,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic      [2:0]          status,
	output logic      [POS_W-1:0]    victim_pos,
	output logic                     last,
	output logic      [KEPT_W-1:0]   kept_count
);

	localparam int AW  = $clog2(MAX_SLOTS);
	localparam int CW  = $clog2(MAX_SLOTS + 1);
	localparam int XW  = ((CW > BUDGET_W) ? CW : BUDGET_W) + 1;
	localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

	logic [BUDGET_W-1:0] budget_q, window_q;
	logic [CW-1:0]       count_q;
	logic [IDX_W-1:0]    aidx_q;
	logic                rmw_s1;
	logic [AW-1:0]       addr_s1;
	logic                out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RST;
			window_q <= WINDOW_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BUDGET) begin
				budget_q <= cfg_data;
			end else begin
				window_q <= cfg_data;
			end
		end
	end

	// Input handshake
	logic ev_busy, out_take, in_acc, is_attn, is_app, is_ev;
	assign out_take = !out_valid_q || !out_stall;
	assign in_stall = ev_busy || ((op != OP_ATTN) && (rmw_s1 || !out_take));
	assign in_acc   = in_valid && !in_stall;
	assign is_attn  = in_acc && (op == OP_ATTN);
	assign is_app   = in_acc && (op == OP_APPEND);
	assign is_ev    = in_acc && (op == OP_EVICT);

	// Vote test for the attention element
	logic [PROD_W-1:0] prod;
	logic [IXW-1:0]    idx_x;
	logic              hit;
	assign prod  = PROD_W'(attn_weight) * PROD_W'(step_len);
	assign idx_x = IXW'(aidx_q);
	assign hit   = (idx_x < IXW'(count_q)) && (aidx_q < step_len) && (prod > ONE_Q16);

	// Append full check
	logic full;
	assign full = (XW'(count_q) >= (XW'(budget_q) + XW'(1))) ||
		(XW'(count_q) >= XW'(MAX_SLOTS));

	// Store ports
	logic              st_rd_en, st_wp_en, st_wv_en;
	logic [AW-1:0]     st_rd_addr, st_wr_addr;
	logic [POS_W-1:0]  st_rd_pos, st_wr_pos;
	logic [VOTE_W-1:0] st_rd_vote, st_wr_vote, vote_inc;
	logic              ev_rd_en, ev_wr_en, ev_cnt_we;
	logic [AW-1:0]     ev_rd_addr, ev_wr_addr;
	logic [POS_W-1:0]  ev_wr_pos;
	logic [VOTE_W-1:0] ev_wr_vote;
	logic [CW-1:0]     ev_cnt_new;
	logic              app_wr;
	res_t              ev_res;

	assign app_wr   = is_app && !full;
	assign vote_inc = (st_rd_vote == '1) ? st_rd_vote : st_rd_vote + VOTE_W'(1);

	// Port arbitration: evict engine owns the store while busy
	always_comb begin
		if (ev_busy) begin
			st_rd_en   = ev_rd_en;
			st_rd_addr = ev_rd_addr;
			st_wp_en   = ev_wr_en;
			st_wv_en   = ev_wr_en;
			st_wr_addr = ev_wr_addr;
			st_wr_pos  = ev_wr_pos;
			st_wr_vote = ev_wr_vote;
		end else begin
			st_rd_en   = is_attn;
			st_rd_addr = idx_x[AW-1:0];
			st_wp_en   = app_wr;
			st_wv_en   = rmw_s1 || app_wr;
			st_wr_addr = rmw_s1 ? addr_s1 : count_q[AW-1:0];
			st_wr_pos  = position;
			st_wr_vote = rmw_s1 ? vote_inc : '0;
		end
	end

	kvev_store #(.MAX_SLOTS(MAX_SLOTS)) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_en      (st_rd_en),
		.rd_addr    (st_rd_addr),
		.rd_pos     (st_rd_pos),
		.rd_vote    (st_rd_vote),
		.wr_pos_en  (st_wp_en),
		.wr_vote_en (st_wv_en),
		.wr_addr    (st_wr_addr),
		.wr_pos     (st_wr_pos),
		.wr_vote    (st_wr_vote)
	);

	kvev_evict #(.MAX_SLOTS(MAX_SLOTS)) u_evict (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (is_ev),
		.room          (victim_room),
		.count         (count_q),
		.budget        (budget_q),
		.keep_recent   (window_q),
		.busy          (ev_busy),
		.res           (ev_res),
		.res_take      (out_take),
		.cnt_we        (ev_cnt_we),
		.cnt_new       (ev_cnt_new),
		.rd_en         (ev_rd_en),
		.rd_addr       (ev_rd_addr),
		.rd_pos        (st_rd_pos),
		.rd_vote       (st_rd_vote),
		.wr_en         (ev_wr_en),
		.wr_addr       (ev_wr_addr),
		.wr_pos        (ev_wr_pos),
		.wr_vote       (ev_wr_vote)
	);

	// Table count, attention index and the vote pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			aidx_q  <= '0;
			rmw_s1  <= 1'b0;
			addr_s1 <= '0;
		end else begin
			rmw_s1  <= is_attn && hit;
			addr_s1 <= idx_x[AW-1:0];
			if (is_attn && aidx_q < IDX_MAX) begin
				aidx_q <= aidx_q + IDX_W'(1);
			end
			if (is_app) begin
				aidx_q <= '0;
			end
			if (app_wr) begin
				count_q <= count_q + CW'(1);
			end else if (ev_cnt_we) begin
				count_q <= ev_cnt_new;
			end
		end
	end

	// Output register
	logic ld_ev, ld_app;
	assign ld_ev  = ev_res.valid && out_take;
	assign ld_app = is_app;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_ev || ld_app) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ev) begin
			status     <= ev_res.status;
			victim_pos <= ev_res.pos;
			last       <= ev_res.last;
			kept_count <= ev_res.kept;
		end else if (ld_app) begin
			status     <= full ? ST_DROPPED : ST_APPENDED;
			victim_pos <= '0;
			last       <= 1'b1;
			kept_count <= full ? KEPT_W'(count_q) : KEPT_W'(count_q + CW'(1));
		end
	end

	assign out_valid = out_valid_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(count_q) <= XW'(MAX_SLOTS))
		else $error("entry count above table depth");

	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(rmw_s1 && app_wr))
		else $error("vote update and append share a write cycle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(ld_ev || ld_app))
		else $error("held result overwritten");

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ev_busy) |-> $past(is_ev))
		else $error("evict engine started without an evict transfer");

endmodule
`default_nettype wire

>>> hw/rtl/kvev_store.sv
`default_nettype none
module kvev_store import kvev_pkg::*; #(
	parameter int MAX_SLOTS = SLOTS_DEF,
	localparam int AW = $clog2(MAX_SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output logic      [POS_W-1:0]  rd_pos,
	output logic      [VOTE_W-1:0] rd_vote,
	input  wire logic              wr_pos_en,
	input  wire logic              wr_vote_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [POS_W-1:0]  wr_pos,
	input  wire logic [VOTE_W-1:0] wr_vote
);

	logic [POS_W-1:0]  pos_mem [MAX_SLOTS];
	logic [VOTE_W-1:0] vote_mem [MAX_SLOTS];
	logic [POS_W-1:0]  pos_q;
	logic [VOTE_W-1:0] vote_q;
	// entry 0 reads as zero until first written after reset
	logic pz_q, vz_q, pz_rd_q, vz_rd_q;

	// Memory arrays, one write and one read port each
	always_ff @(posedge clk) begin
		if (wr_pos_en) begin
			pos_mem[wr_addr] <= wr_pos;
		end
		if (wr_vote_en) begin
			vote_mem[wr_addr] <= wr_vote;
		end
		if (rd_en) begin
			pos_q  <= pos_mem[rd_addr];
			vote_q <= vote_mem[rd_addr];
		end
	end

	// Entry 0 zero flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pz_q    <= 1'b1;
			vz_q    <= 1'b1;
			pz_rd_q <= 1'b0;
			vz_rd_q <= 1'b0;
		end else begin
			if (rd_en) begin
				pz_rd_q <= pz_q && (rd_addr == '0);
				vz_rd_q <= vz_q && (rd_addr == '0);
			end
			if (wr_pos_en && wr_addr == '0) begin
				pz_q <= 1'b0;
			end
			if (wr_vote_en && wr_addr == '0) begin
				vz_q <= 1'b0;
			end
		end
	end

	assign rd_pos  = pz_rd_q ? '0 : pos_q;
	assign rd_vote = vz_rd_q ? '0 : vote_q;

endmodule
`default_nettype wire

>>> hw/rtl/kvev_evict.sv
`default_nettype none
module kvev_evict import kvev_pkg::*; #(
	parameter int MAX_SLOTS = SLOTS_DEF,
	localparam int AW = $clog2(MAX_SLOTS),
	localparam int CW = $clog2(MAX_SLOTS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [ROOM_W-1:0]   room,
	input  wire logic [CW-1:0]       count,
	input  wire logic [BUDGET_W-1:0] budget,
	input  wire logic [BUDGET_W-1:0] keep_recent,
	output logic                     busy,
	output res_t                     res,
	input  wire logic                res_take,
	output logic                     cnt_we,
	output logic      [CW-1:0]       cnt_new,
	output logic                     rd_en,
	output logic      [AW-1:0]       rd_addr,
	input  wire logic [POS_W-1:0]    rd_pos,
	input  wire logic [VOTE_W-1:0]   rd_vote,
	output logic                     wr_en,
	output logic      [AW-1:0]       wr_addr,
	output logic      [POS_W-1:0]    wr_pos,
	output logic      [VOTE_W-1:0]   wr_vote
);

	localparam int XW = ((CW > BUDGET_W) ? CW : BUDGET_W) + 1;

	typedef enum logic [2:0] {
		E_IDLE, E_DECIDE, E_SEL, E_CMP_RD, E_CMP_PROC, E_REPORT, E_DONE
	} state_t;

	state_t            state_q;
	logic [ROOM_W-1:0] room_q, need_q, pass_q, emit_q;
	logic [CW-1:0]     end_q, i_q, r_q, w_q;
	status_t           rep_q;
	logic              have_q, found_q;
	logic [VOTE_W-1:0] lv_q, bv_q;
	logic [AW-1:0]     li_q, bi_q;
	logic              rv_s1;
	logic [AW-1:0]     ri_s1;

	// Sizing of the eviction
	logic [XW-1:0] c_x, b_x, g_x, e_x, n_x, nn_x;
	always_comb begin
		c_x  = XW'(count);
		b_x  = XW'(budget);
		g_x  = (XW'(keep_recent) < c_x) ? XW'(keep_recent) : c_x;
		e_x  = c_x - g_x;
		n_x  = c_x - b_x;
		nn_x = (n_x > e_x) ? e_x : n_x;
	end

	// Key compare for the selection scan
	logic sel_issue, cand, better, sel_end;
	assign sel_issue = (state_q == E_SEL) && (i_q < end_q);
	assign cand   = !have_q || (rd_vote > lv_q) || (rd_vote == lv_q && ri_s1 > li_q);
	assign better = !found_q || (rd_vote < bv_q);
	assign sel_end = (state_q == E_SEL) && (i_q == end_q) && !rv_s1;

	// Victim test during compaction
	logic vic, cmp_last;
	assign vic = (r_q < end_q) &&
		((rd_vote < lv_q) || (rd_vote == lv_q && r_q[AW-1:0] <= li_q));
	assign cmp_last = (r_q + CW'(1)) == count;

	logic [CW-1:0] kept_after;
	assign kept_after = count - CW'(need_q);

	// Memory port and result drive
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = w_q[AW-1:0];
		wr_pos  = rd_pos;
		wr_vote = rd_vote;
		res     = '0;
		cnt_we  = 1'b0;
		cnt_new = kept_after;
		case (state_q)
			E_SEL: begin
				rd_en = sel_issue;
			end
			E_CMP_RD: begin
				rd_en   = 1'b1;
				rd_addr = r_q[AW-1:0];
			end
			E_CMP_PROC: begin
				wr_en      = !vic;
				res.valid  = vic;
				res.status = ST_VICTIM;
				res.pos    = rd_pos;
				res.last   = (emit_q + ROOM_W'(1)) == need_q;
				res.kept   = KEPT_W'(kept_after);
			end
			E_REPORT: begin
				res.valid  = 1'b1;
				res.status = rep_q;
				res.last   = 1'b1;
				res.kept   = KEPT_W'(count);
			end
			E_DONE: begin
				cnt_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != E_IDLE);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			room_q  <= '0;
			need_q  <= '0;
			pass_q  <= '0;
			emit_q  <= '0;
			end_q   <= '0;
			i_q     <= '0;
			r_q     <= '0;
			w_q     <= '0;
			rep_q   <= ST_NONE;
			have_q  <= 1'b0;
			found_q <= 1'b0;
			lv_q    <= '0;
			bv_q    <= '0;
			li_q    <= '0;
			bi_q    <= '0;
			rv_s1   <= 1'b0;
			ri_s1   <= '0;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (start) begin
						room_q  <= (room > ROOM_CAP) ? ROOM_CAP : room;
						state_q <= E_DECIDE;
					end
				end
				E_DECIDE: begin
					have_q  <= 1'b0;
					found_q <= 1'b0;
					pass_q  <= '0;
					i_q     <= '0;
					rv_s1   <= 1'b0;
					end_q   <= e_x[CW-1:0];
					if (c_x <= b_x) begin
						rep_q   <= ST_NONE;
						state_q <= E_REPORT;
					end else if (nn_x > XW'(room_q)) begin
						rep_q   <= ST_REFUSED;
						state_q <= E_REPORT;
					end else if (nn_x == '0) begin
						rep_q   <= ST_NONE;
						state_q <= E_REPORT;
					end else begin
						need_q  <= nn_x[ROOM_W-1:0];
						state_q <= E_SEL;
					end
				end
				E_SEL: begin
					rv_s1 <= sel_issue;
					ri_s1 <= i_q[AW-1:0];
					if (sel_issue) begin
						i_q <= i_q + CW'(1);
					end
					if (rv_s1 && cand && better) begin
						found_q <= 1'b1;
						bv_q    <= rd_vote;
						bi_q    <= ri_s1;
					end
					// pass over: the best key becomes the lower bound
					if (sel_end) begin
						lv_q    <= bv_q;
						li_q    <= bi_q;
						have_q  <= 1'b1;
						found_q <= 1'b0;
						i_q     <= '0;
						pass_q  <= pass_q + ROOM_W'(1);
						if ((pass_q + ROOM_W'(1)) == need_q) begin
							r_q     <= '0;
							w_q     <= '0;
							emit_q  <= '0;
							state_q <= E_CMP_RD;
						end
					end
				end
				E_CMP_RD: begin
					state_q <= E_CMP_PROC;
				end
				E_CMP_PROC: begin
					if (!vic || res_take) begin
						if (vic) begin
							emit_q <= emit_q + ROOM_W'(1);
						end else begin
							w_q <= w_q + CW'(1);
						end
						r_q     <= r_q + CW'(1);
						state_q <= cmp_last ? E_DONE : E_CMP_RD;
					end
				end
				E_REPORT: begin
					if (res_take) begin
						state_q <= E_IDLE;
					end
				end
				E_DONE: begin
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
